// ----- sv/hswq_pkg.sv -----
package hswq_pkg;

  localparam int MAX_THREADS_DEF = 32;
  localparam int BUCKETS_DEF     = 127;
  localparam int RESULT_CAP      = 32;

  localparam int FUNC_W = 2;
  localparam int TID_W  = 5;
  localparam int KEY_W  = 32;

  localparam int HASH_BITS  = 8;
  localparam int HASH_STEPS = KEY_W / HASH_BITS;
  localparam int HC_W       = $clog2(HASH_STEPS);

  localparam logic [FUNC_W-1:0] FUNC_ADD      = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_WAKE     = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_WAKE_ALL = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HASH,
    ST_HEAD,
    ST_LOAD,
    ST_RD,
    ST_CHK,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic capture;
    logic hash_step;
    logic tid_init;
    logic load_cur;
    logic head_wr_tid;
    logic step_fwd;
    logic keep_prev;
    logic unlink;
    logic take;
    logic append_tail;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic op_ok;
    logic is_add;
    logic is_all;
    logic hash_last;
    logic head_zero;
    logic cur_zero;
    logic nx_zero;
    logic match;
    logic steps_max;
    logic n_cap;
  } status_t;

endpackage

// ----- sv/hswq_ram.sv -----
module hswq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/hswq_ctrl.sv -----
module hswq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  hswq_pkg::status_t status,
  output hswq_pkg::cmd_t    cmd,
  output logic              busy
);

  hswq_pkg::state_t state;
  hswq_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hswq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      hswq_pkg::ST_IDLE: begin
        if (start && status.op_ok) state_next = hswq_pkg::ST_HASH;
      end
      hswq_pkg::ST_HASH: begin
        if (status.hash_last) state_next = hswq_pkg::ST_HEAD;
      end
      hswq_pkg::ST_HEAD: begin
        state_next = hswq_pkg::ST_LOAD;
      end
      hswq_pkg::ST_LOAD: begin
        if (status.is_add && status.head_zero) state_next = hswq_pkg::ST_IDLE;
        else state_next = hswq_pkg::ST_RD;
      end
      hswq_pkg::ST_RD: begin
        if (status.is_add) state_next = hswq_pkg::ST_CHK;
        else if (status.cur_zero) state_next = hswq_pkg::ST_FINISH;
        else if (status.is_all && (status.steps_max || status.n_cap)) begin
          state_next = hswq_pkg::ST_FINISH;
        end else state_next = hswq_pkg::ST_CHK;
      end
      hswq_pkg::ST_CHK: begin
        if (status.is_add) begin
          if (!status.nx_zero && !status.steps_max) state_next = hswq_pkg::ST_RD;
          else state_next = hswq_pkg::ST_IDLE;
        end else if (status.is_all) begin
          state_next = hswq_pkg::ST_RD;
        end else if (status.match || status.steps_max) begin
          state_next = hswq_pkg::ST_FINISH;
        end else begin
          state_next = hswq_pkg::ST_RD;
        end
      end
      hswq_pkg::ST_FINISH: begin
        state_next = hswq_pkg::ST_IDLE;
      end
      default: begin
        state_next = hswq_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state)
      hswq_pkg::ST_IDLE: begin
        busy        = 1'b0;
        cmd.capture = start;
      end
      hswq_pkg::ST_HASH: begin
        cmd.hash_step = 1'b1;
      end
      hswq_pkg::ST_HEAD: begin
        cmd.tid_init = status.is_add;
      end
      hswq_pkg::ST_LOAD: begin
        cmd.load_cur    = 1'b1;
        cmd.head_wr_tid = status.is_add && status.head_zero;
      end
      hswq_pkg::ST_RD: begin
        cmd = '0;
      end
      hswq_pkg::ST_CHK: begin
        if (status.is_add) begin
          if (!status.nx_zero && !status.steps_max) cmd.step_fwd = 1'b1;
          else cmd.append_tail = 1'b1;
        end else if (status.is_all) begin
          cmd.step_fwd  = 1'b1;
          cmd.unlink    = status.match;
          cmd.take      = status.match;
          cmd.keep_prev = !status.match;
        end else if (status.match) begin
          cmd.unlink = 1'b1;
          cmd.take   = 1'b1;
        end else if (!status.steps_max) begin
          cmd.keep_prev = 1'b1;
          cmd.step_fwd  = 1'b1;
        end
      end
      hswq_pkg::ST_FINISH: begin
        cmd.finish = 1'b1;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

endmodule

// ----- sv/hswq_dp.sv -----
module hswq_dp #(
  parameter int MAX_THREADS = hswq_pkg::MAX_THREADS_DEF,
  parameter int BUCKETS     = hswq_pkg::BUCKETS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [hswq_pkg::FUNC_W-1:0]  func,
  input  logic [hswq_pkg::TID_W-1:0]   thread_id,
  input  logic [hswq_pkg::KEY_W-1:0]   resource_key,
  input  hswq_pkg::cmd_t               cmd,
  output hswq_pkg::status_t            status,
  output logic                         strobe,
  output logic                         found,
  output logic [hswq_pkg::TID_W-1:0]   woken_thread,
  output logic                         last
);

  localparam int TW = $clog2(MAX_THREADS);
  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int SW = $clog2(MAX_THREADS + 1);
  localparam int NW = $clog2(hswq_pkg::RESULT_CAP + 1);
  localparam logic [BW:0] BK = (BW + 1)'(BUCKETS);

  logic [hswq_pkg::FUNC_W-1:0]    func_r;
  logic [TW-1:0]                  tid_r;
  logic [hswq_pkg::KEY_W-1:0]     key_r;
  logic [BW-1:0]                  rem;
  logic [BW-1:0]                  rem_next;
  logic [hswq_pkg::HC_W-1:0]      hcnt;
  logic [hswq_pkg::HASH_BITS-1:0] chunk;
  logic [BW:0]                    acc;
  logic [TW-1:0]                  cur;
  logic [TW-1:0]                  prev;
  logic [SW-1:0]                  steps;
  logic [NW-1:0]                  n_res;
  logic [TW-1:0]                  pend;
  logic                           pend_vld;

  logic [BUCKETS-1:0]     head_vld;
  logic [MAX_THREADS-1:0] nxt_vld;
  logic [MAX_THREADS-1:0] nxt_vld_next;
  logic [MAX_THREADS-1:0] key_vld;
  logic                   head_rvld;
  logic                   nxt_rvld;
  logic                   key_rvld;

  logic                       head_we;
  logic [TW-1:0]              head_wdata;
  logic [TW-1:0]              head_rdata;
  logic                       nxt_we;
  logic [TW-1:0]              nxt_waddr;
  logic [TW-1:0]              nxt_wdata;
  logic [TW-1:0]              nxt_rdata;
  logic [hswq_pkg::KEY_W-1:0] key_rdata;

  logic [TW-1:0] head_val;
  logic [TW-1:0] nx;
  logic          match;

  // key mod buckets, msb first, one compare-subtract per bit
  assign chunk = key_r[hcnt * hswq_pkg::HASH_BITS +: hswq_pkg::HASH_BITS];

  always_comb begin
    acc = {1'b0, rem};
    for (int i = hswq_pkg::HASH_BITS - 1; i >= 0; i--) begin
      acc = {acc[BW-1:0], chunk[i]};
      if (acc >= BK) acc = acc - BK;
    end
    rem_next = acc[BW-1:0];
  end

  // entries never written read as zero
  assign head_val = head_rvld ? head_rdata : '0;
  assign nx       = nxt_rvld ? nxt_rdata : '0;
  assign match    = key_rvld ? (key_rdata == key_r) : (key_r == '0);

  assign head_we    = cmd.head_wr_tid || (cmd.unlink && prev == '0);
  assign head_wdata = cmd.head_wr_tid ? tid_r : nx;
  assign nxt_we     = cmd.append_tail || (cmd.unlink && prev != '0);
  assign nxt_waddr  = cmd.append_tail ? cur : prev;
  assign nxt_wdata  = cmd.append_tail ? tid_r : nx;

  hswq_ram #(.WIDTH(TW), .DEPTH(BUCKETS), .AW(BW)) u_head_ram (
    .clk   (clk),
    .we    (head_we),
    .waddr (rem),
    .wdata (head_wdata),
    .raddr (rem),
    .rdata (head_rdata)
  );

  hswq_ram #(.WIDTH(TW), .DEPTH(MAX_THREADS), .AW(TW)) u_next_ram (
    .clk   (clk),
    .we    (nxt_we),
    .waddr (nxt_waddr),
    .wdata (nxt_wdata),
    .raddr (cur),
    .rdata (nxt_rdata)
  );

  hswq_ram #(.WIDTH(hswq_pkg::KEY_W), .DEPTH(MAX_THREADS), .AW(TW)) u_key_ram (
    .clk   (clk),
    .we    (cmd.tid_init),
    .waddr (tid_r),
    .wdata (key_r),
    .raddr (cur),
    .rdata (key_rdata)
  );

  // clears after sets so an unlinked node ends empty
  always_comb begin
    nxt_vld_next = nxt_vld;
    if (nxt_we) nxt_vld_next[nxt_waddr] = 1'b1;
    if (cmd.tid_init) nxt_vld_next[tid_r] = 1'b0;
    if (cmd.unlink) nxt_vld_next[cur] = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_vld <= '0;
      nxt_vld  <= '0;
      key_vld  <= '0;
    end else begin
      if (head_we) head_vld[rem] <= 1'b1;
      nxt_vld <= nxt_vld_next;
      if (cmd.tid_init) key_vld[tid_r] <= 1'b1;
      if (cmd.unlink) key_vld[cur] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    head_rvld <= head_vld[rem];
    nxt_rvld  <= nxt_vld[cur];
    key_rvld  <= key_vld[cur];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r <= func;
      tid_r  <= TW'(thread_id);
      key_r  <= resource_key;
      rem    <= '0;
      hcnt   <= hswq_pkg::HC_W'(hswq_pkg::HASH_STEPS - 1);
      steps  <= '0;
      n_res  <= '0;
      prev   <= '0;
      pend   <= '0;
    end
    if (cmd.hash_step) begin
      rem  <= rem_next;
      hcnt <= hcnt - hswq_pkg::HC_W'(1);
    end
    if (cmd.load_cur) cur <= head_val;
    if (cmd.step_fwd) begin
      cur   <= nx;
      steps <= steps + SW'(1);
    end
    if (cmd.keep_prev) prev <= cur;
    if (cmd.take) begin
      pend  <= cur;
      n_res <= n_res + NW'(1);
    end
  end

  // one result held back so the final one can carry last
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_vld <= 1'b0;
      strobe   <= 1'b0;
    end else begin
      if (cmd.capture) pend_vld <= 1'b0;
      else if (cmd.take) pend_vld <= 1'b1;
      strobe <= (cmd.take && pend_vld) || cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      found        <= 1'b1;
      woken_thread <= hswq_pkg::TID_W'(pend);
      last         <= 1'b0;
    end else if (cmd.finish) begin
      found        <= pend_vld;
      woken_thread <= pend_vld ? hswq_pkg::TID_W'(pend) : '0;
      last         <= 1'b1;
    end
  end

  always_comb begin
    status.op_ok = (func inside {hswq_pkg::FUNC_WAKE, hswq_pkg::FUNC_WAKE_ALL}) ||
                   (func == hswq_pkg::FUNC_ADD && thread_id != '0 &&
                    32'(thread_id) < MAX_THREADS);
    status.is_add    = func_r == hswq_pkg::FUNC_ADD;
    status.is_all    = func_r == hswq_pkg::FUNC_WAKE_ALL;
    status.hash_last = hcnt == '0;
    status.head_zero = head_val == '0;
    status.cur_zero  = cur == '0;
    status.nx_zero   = nx == '0;
    status.match     = match;
    status.steps_max = steps == SW'(MAX_THREADS);
    status.n_cap     = n_res == NW'(hswq_pkg::RESULT_CAP);
  end

endmodule

// ----- sv/hashed_sleep_wait_queue.sv -----
// hashed wait queue: threads wait on 32-bit keys in buckets chosen by key mod BUCKETS,
// each bucket a list in arrival order chained through per-thread links.
// command port: an item (func, thread_id, resource_key) transfers on a rising edge
// with start high and busy low. func 0 appends a thread, 1 wakes the first
// thread with the key, 2 wakes every thread with the key.
// results come out on found, woken_thread and last, each for one cycle with
// strobe high; the receiver cannot stall, so a result is taken in that cycle.
// adds give no result; a wake gives one; a wake-all gives one per thread woken,
// or a single not-found result; last marks the final result of the item.
// sequence: the key is hashed a byte at a time, msb first, then the bucket head is
// read, then each chain entry visited takes one link/key memory read and one update;
// a wake then passes through a report state before busy drops. the last result
// appears in the same cycle that busy drops. chain walks stop once MAX_THREADS
// links have been followed, so busy always falls again.
// reset empties every bucket and clears all links and keys at once, through
// flags per entry; no clearing pass is needed and an item may start right away.
module hashed_sleep_wait_queue #(
  parameter int MAX_THREADS = hswq_pkg::MAX_THREADS_DEF,
  parameter int BUCKETS     = hswq_pkg::BUCKETS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [hswq_pkg::FUNC_W-1:0] func,
  input  logic [hswq_pkg::TID_W-1:0]  thread_id,
  input  logic [hswq_pkg::KEY_W-1:0]  resource_key,
  output logic                        strobe,
  output logic                        found,
  output logic [hswq_pkg::TID_W-1:0]  woken_thread,
  output logic                        last
);

  hswq_pkg::cmd_t    cmd;
  hswq_pkg::status_t status;

  hswq_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  hswq_dp #(.MAX_THREADS(MAX_THREADS), .BUCKETS(BUCKETS)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .func         (func),
    .thread_id    (thread_id),
    .resource_key (resource_key),
    .cmd          (cmd),
    .status       (status),
    .strobe       (strobe),
    .found        (found),
    .woken_thread (woken_thread),
    .last         (last)
  );

`ifndef SYNTHESIS
  a_more_follows: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |=> busy)
    else $error("non-final result while block went idle");

  a_no_result_after_accept: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> !strobe)
    else $error("result right after a new item transfer");

  a_miss_is_final: assert property (@(posedge clk) disable iff (rst)
    strobe && !found |-> last && woken_thread == '0)
    else $error("not-found result without last or with a thread");
`endif

endmodule

// ----- test/testbench.sv -----
module testbench;
  import hswq_pkg::*;

  localparam int NTHR = MAX_THREADS_DEF;
  localparam int unsigned NBKT = BUCKETS_DEF;
  localparam logic [FUNC_W-1:0] FUNC_BAD = 2'd3;
  localparam int RANDOM_ITEMS = 107;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 100;

  typedef struct {
    logic found;
    logic [TID_W-1:0] woken;
    logic last;
  } wake_t;

  typedef struct {
    logic [FUNC_W-1:0] fn;
    logic [TID_W-1:0] tid;
    logic [KEY_W-1:0] key;
    bit typed;
    int n_res;
    logic e_found;
    logic [TID_W-1:0] e_woken;
  } row_t;

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  logic [FUNC_W-1:0] func;
  logic [TID_W-1:0] thread_id;
  logic [KEY_W-1:0] resource_key;
  logic strobe;
  logic found;
  logic [TID_W-1:0] woken_thread;
  logic last;

  // own copy of the bucket table and per-thread chain
  logic [TID_W-1:0] head_of [NBKT];
  logic [TID_W-1:0] link_to [NTHR];
  logic [KEY_W-1:0] key_held [NTHR];

  wake_t due_wakeups [$];
  wake_t step_wakeups [$];
  bit [NTHR-1:0] in_queue;
  int mismatches = 0;
  int cycles = 0;

  hashed_sleep_wait_queue DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .func(func),
    .thread_id(thread_id),
    .resource_key(resource_key),
    .strobe(strobe),
    .found(found),
    .woken_thread(woken_thread),
    .last(last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("%0t: %s got %0d expected %0d", $time, what, got, want);
  endtask

  task automatic unchain(input int unsigned b, input logic [TID_W-1:0] prev,
                         input logic [TID_W-1:0] cur);
    if (prev == 0) head_of[b] = link_to[cur];
    else link_to[prev] = link_to[cur];
    link_to[cur] = '0;
    key_held[cur] = '0;
  endtask

  // advances the queue copy by one item and leaves its wakeups in step_wakeups
  task automatic wait_queue_step(input logic [FUNC_W-1:0] fn, input logic [TID_W-1:0] tid,
                                 input logic [KEY_W-1:0] key);
    int unsigned b;
    int steps;
    int n;
    logic [TID_W-1:0] prev;
    logic [TID_W-1:0] cur;
    logic [TID_W-1:0] nx;
    b = key % NBKT;
    steps = 0;
    n = 0;
    prev = '0;
    step_wakeups.delete();
    case (fn)
      FUNC_ADD: begin
        if (tid != 0) begin
          link_to[tid] = '0;
          key_held[tid] = key;
          cur = head_of[b];
          if (cur == 0) begin
            head_of[b] = tid;
          end else begin
            // walk to the tail, bounded in case the chain loops
            while (link_to[cur] != 0 && steps < NTHR) begin
              cur = link_to[cur];
              steps++;
            end
            link_to[cur] = tid;
          end
        end
      end
      FUNC_WAKE: begin
        cur = head_of[b];
        while (cur != 0 && steps < NTHR && key_held[cur] != key) begin
          prev = cur;
          cur = link_to[cur];
          steps++;
        end
        if (cur != 0 && key_held[cur] == key) begin
          unchain(b, prev, cur);
          step_wakeups.push_back('{1'b1, cur, 1'b1});
        end else begin
          step_wakeups.push_back('{1'b0, '0, 1'b1});
        end
      end
      FUNC_WAKE_ALL: begin
        cur = head_of[b];
        while (cur != 0 && steps < NTHR && n < RESULT_CAP) begin
          nx = link_to[cur];
          steps++;
          if (key_held[cur] == key) begin
            unchain(b, prev, cur);
            step_wakeups.push_back('{1'b1, cur, 1'b0});
            n++;
          end else begin
            prev = cur;
          end
          cur = nx;
        end
        if (n == 0) step_wakeups.push_back('{1'b0, '0, 1'b1});
        else step_wakeups[n-1].last = 1'b1;
      end
      default: ;
    endcase
  endtask

  // holds the item on the command port until its transfer
  task automatic transfer_item(input logic [FUNC_W-1:0] fn, input logic [TID_W-1:0] tid,
                               input logic [KEY_W-1:0] key, input bit use_model);
    start <= 1'b1;
    func <= fn;
    thread_id <= tid;
    resource_key <= key;
    do @(posedge clk); while (busy !== 1'b0);
    wait_queue_step(fn, tid, key);
    if (fn == FUNC_ADD && tid != 0) in_queue[tid] = 1'b1;
    foreach (step_wakeups[j]) begin
      if (step_wakeups[j].found) in_queue[step_wakeups[j].woken] = 1'b0;
      if (use_model) due_wakeups.push_back(step_wakeups[j]);
    end
  endtask

  task automatic maybe_pause(input bit quiet);
    int n;
    if (!quiet && $urandom_range(99) < 9) begin
      n = $urandom_range(1, 20);
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin : result_check
    wake_t w;
    if (!rst && strobe === 1'b1) begin
      if (due_wakeups.size() == 0) begin
        report_mismatch("unexpected result, woken_thread", 32'(woken_thread), 0);
      end else begin
        w = due_wakeups.pop_front();
        if (found !== w.found) report_mismatch("found", 32'(found), 32'(w.found));
        if (woken_thread !== w.woken) begin
          report_mismatch("woken_thread", 32'(woken_thread), 32'(w.woken));
        end
        if (last !== w.last) report_mismatch("last", 32'(last), 32'(w.last));
      end
    end
  end

  row_t plan [23] = '{
    '{FUNC_WAKE,     5'd31, 32'h0000_0000, 1'b1, 1, 1'b0, 5'd0},
    '{FUNC_WAKE_ALL, 5'd0,  32'hFFFF_FFFF, 1'b1, 1, 1'b0, 5'd0},
    '{FUNC_ADD,      5'd1,  32'h0000_0000, 1'b1, 0, 1'b0, 5'd0},
    '{FUNC_ADD,      5'd31, 32'hFFFF_FFFF, 1'b1, 0, 1'b0, 5'd0},
    '{FUNC_ADD,      5'd0,  32'h0000_0000, 1'b1, 0, 1'b0, 5'd0},
    '{FUNC_BAD,      5'd5,  32'h0000_0000, 1'b1, 0, 1'b0, 5'd0},
    '{FUNC_WAKE,     5'd0,  32'h0000_0000, 1'b1, 1, 1'b1, 5'd1},
    '{FUNC_WAKE_ALL, 5'd0,  32'hFFFF_FFFF, 1'b1, 1, 1'b1, 5'd31},
    // one bucket shared by keys 5, 132 and 259
    '{FUNC_ADD,      5'd2,  32'd5,         1'b1, 0, 1'b0, 5'd0},
    '{FUNC_ADD,      5'd3,  32'd132,       1'b1, 0, 1'b0, 5'd0},
    '{FUNC_ADD,      5'd4,  32'd5,         1'b1, 0, 1'b0, 5'd0},
    '{FUNC_ADD,      5'd5,  32'd259,       1'b1, 0, 1'b0, 5'd0},
    '{FUNC_ADD,      5'd6,  32'd5,         1'b1, 0, 1'b0, 5'd0},
    '{FUNC_WAKE,     5'd0,  32'd132,       1'b1, 1, 1'b1, 5'd3},
    '{FUNC_WAKE_ALL, 5'd0,  32'd5,         1'b0, 0, 1'b0, 5'd0},
    '{FUNC_WAKE,     5'd17, 32'd5,         1'b1, 1, 1'b0, 5'd0},
    '{FUNC_WAKE,     5'd0,  32'd259,       1'b1, 1, 1'b1, 5'd5},
    // thread added again while queued, leaving a looped chain
    '{FUNC_ADD,      5'd7,  32'd10,        1'b1, 0, 1'b0, 5'd0},
    '{FUNC_ADD,      5'd8,  32'd10,        1'b1, 0, 1'b0, 5'd0},
    '{FUNC_ADD,      5'd7,  32'd137,       1'b1, 0, 1'b0, 5'd0},
    '{FUNC_WAKE_ALL, 5'd0,  32'd137,       1'b0, 0, 1'b0, 5'd0},
    '{FUNC_WAKE,     5'd0,  32'd10,        1'b0, 0, 1'b0, 5'd0},
    '{FUNC_WAKE_ALL, 5'd0,  32'd10,        1'b0, 0, 1'b0, 5'd0}
  };

  initial begin
    logic [KEY_W-1:0] key_pool [8];
    logic [KEY_W-1:0] base;
    logic [FUNC_W-1:0] fn;
    logic [TID_W-1:0] tid;
    logic [KEY_W-1:0] key;
    int free_tids [$];
    int done_items;
    int r;
    bit quiet;

    rst <= 1'b1;
    start <= 1'b0;
    func <= FUNC_ADD;
    thread_id <= '0;
    resource_key <= '0;
    for (int b = 0; b < NBKT; b++) head_of[b] = '0;
    for (int t = 0; t < NTHR; t++) begin
      link_to[t] = '0;
      key_held[t] = '0;
    end
    in_queue = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      transfer_item(plan[i].fn, plan[i].tid, plan[i].key, !plan[i].typed);
      if (plan[i].typed && plan[i].n_res == 1)
        due_wakeups.push_back('{plan[i].e_found, plan[i].e_woken, 1'b1});
      maybe_pause(1'b0);
    end

    // half the keys share one bucket so chains grow long
    base = $urandom;
    for (int j = 0; j < 4; j++) key_pool[j] = base + 127 * j;
    for (int j = 4; j < 8; j++) key_pool[j] = $urandom;

    done_items = 0;
    while (done_items < RANDOM_ITEMS) begin
      quiet = done_items >= 40 && done_items < 80;
      free_tids.delete();
      for (int t = 1; t < NTHR; t++) if (!in_queue[t]) free_tids.push_back(t);
      key = key_pool[$urandom_range(7)];
      tid = TID_W'($urandom_range(31));
      r = $urandom_range(99);
      if (r < 8) begin
        fn = FUNC_W'($urandom_range(3));
        if ($urandom_range(1)) key = $urandom;
      end else if (r < 58 && free_tids.size() > 0) begin
        fn = FUNC_ADD;
        tid = TID_W'(free_tids[$urandom_range(free_tids.size() - 1)]);
      end else if (r < 80) begin
        fn = FUNC_WAKE;
      end else begin
        fn = FUNC_WAKE_ALL;
      end
      transfer_item(fn, tid, key, 1'b1);
      if (!(fn == FUNC_BAD || (fn == FUNC_ADD && tid == 0))) done_items++;
      maybe_pause(quiet);
    end
    start <= 1'b0;

    while (due_wakeups.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

// ----- hashed_sleep_wait_queue.f -----
sv/hswq_pkg.sv
sv/hswq_ram.sv
sv/hswq_ctrl.sv
sv/hswq_dp.sv
sv/hashed_sleep_wait_queue.sv
test/testbench.sv
